[design/aim_lock_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// aim_lock_sequencer_assert.svh
// Assertion macros shared by the aim lock sequencer checker
// ----------------------------------------------------------------------------
`ifndef AIM_LOCK_SEQUENCER_ASSERT_SVH
`define AIM_LOCK_SEQUENCER_ASSERT_SVH

// clocked assertion, disabled while in reset, generic message
`define ALS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("aim lock sequencer check failed");

// clocked assertion, disabled while in reset, caller message
`define ALS_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

[design/als_pkg.sv]
// ----------------------------------------------------------------------------
// als_pkg
// Types and codes of the aim lock sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package als_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK        = 2'd0;
	localparam logic [1:0] CMD_START_ONCE  = 2'd1;
	localparam logic [1:0] CMD_START_TRACK = 2'd2;
	localparam logic [1:0] CMD_STOP        = 2'd3;

	// mode codes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_ONCE   = 3'd1;
	localparam logic [2:0] MODE_TRACK  = 3'd2;
	localparam logic [2:0] MODE_LOCKED = 3'd3;
	localparam logic [2:0] MODE_ERROR  = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_TARGET = 3'd1;
	localparam logic [2:0] ERR_TIMEOUT   = 3'd2;
	localparam logic [2:0] ERR_GIMBAL    = 3'd3;
	localparam logic [2:0] ERR_CAL       = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_DEFAULT_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_TRACK_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_LOCK_TOLERANCE  = 2'd2;

	// reset values and saturation limits
	localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd2000;
	localparam logic [9:0]  TRACK_INTERVAL_RST  = 10'd50;
	localparam logic [7:0]  LOCK_TOLERANCE_RST  = 8'd4;
	localparam logic [15:0] ELAPSED_MAX         = 16'hFFFF;
	localparam logic [9:0]  GAP_MAX             = 10'h3FF;
	localparam logic [14:0] ABS_MAX             = 15'h7FFF;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        once_tmo;
		logic               calibrated;
		logic               gimbal_busy;
		logic               target_valid;
		logic signed [15:0] err_x;
		logic signed [15:0] err_y;
		logic               move_accepted;
	} als_in_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [2:0]         last_error;
		logic               move_request;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic               stop_request;
		logic               start_ok;
		logic [15:0]        mode_elapsed_ms;
	} als_out_t;

	// magnitude of a pixel error, most negative value saturates
	function automatic logic [14:0] mag16(input logic signed [15:0] v);
		logic [15:0] neg;
		neg = 16'd0 - v;
		if (!v[15]) begin
			mag16 = v[14:0];
		end else if (v == 16'sh8000) begin
			mag16 = ABS_MAX;
		end else begin
			mag16 = neg[14:0];
		end
	endfunction

endpackage

`default_nettype wire

[design/aim_lock_sequencer.sv]
// ----------------------------------------------------------------------------
// aim_lock_sequencer
// Aiming sequencer: idle, once, tracking, locked and error modes
// ----------------------------------------------------------------------------
// Takes one command per clock (tick, start once, start track, stop) while
// cmd_stall is low, with the gimbal and vision status, and returns one result
// per command. A command is captured in an input register and resolved in a
// single pass of compare and counter logic into the result register, which
// offers the result; a new command can be taken every cycle while res_stall is
// low. A result held by the downstream stall leaves room for one more command
// in the input register, after which the command side stalls too; the user
// makes configuration writes only while idle, which the block does not enforce.
`default_nettype none

module aim_lock_sequencer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  als_pkg::als_in_t     cmd_item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output als_pkg::als_out_t    res_item,
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_index,
	input  wire  [15:0]          cfg_data
);
	import als_pkg::*;

	// configuration registers
	logic [15:0] default_timeout_q;
	logic [9:0]  track_interval_q;
	logic [7:0]  lock_tolerance_q;

	// sequencer state
	logic [2:0]  mode_q;
	logic [2:0]  error_q;
	logic [15:0] elapsed_q;
	logic [9:0]  gap_q;
	logic [15:0] timeout_q;

	// pipeline registers
	logic        valid_s1;
	als_in_t     item_s1;
	logic        valid_s2;
	als_out_t    item_s2;

	logic        adv_s2;
	logic        load_s1;

	// next state and result
	logic [2:0]  mode_n;
	logic [2:0]  error_n;
	logic [15:0] elapsed_n;
	logic [9:0]  gap_n;
	logic [15:0] timeout_n;
	als_out_t    res_n;
	logic        on_target;
	logic        do_move;

	// handshake
	assign adv_s2    = valid_s1 && (!valid_s2 || !res_stall);
	assign load_s1   = cmd_valid && !cmd_stall;
	assign cmd_stall = valid_s1 && !adv_s2;
	assign res_valid = valid_s2;
	assign res_item  = item_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_timeout_q <= DEFAULT_TIMEOUT_RST;
			track_interval_q  <= TRACK_INTERVAL_RST;
			lock_tolerance_q  <= LOCK_TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEFAULT_TIMEOUT: default_timeout_q <= cfg_data;
				REG_TRACK_INTERVAL:  track_interval_q  <= cfg_data[9:0];
				REG_LOCK_TOLERANCE:  lock_tolerance_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// on-target test on the captured errors
	assign on_target = ({7'd0, lock_tolerance_q} >= mag16(item_s1.err_x)) &&
		({7'd0, lock_tolerance_q} >= mag16(item_s1.err_y));

	// command resolution
	always_comb begin
		mode_n    = mode_q;
		error_n   = error_q;
		elapsed_n = elapsed_q;
		gap_n     = gap_q;
		timeout_n = timeout_q;
		do_move   = 1'b0;
		res_n     = '0;

		unique case (item_s1.cmd)
			CMD_TICK: begin
				if (elapsed_q != ELAPSED_MAX) begin
					elapsed_n = elapsed_q + 16'd1;
				end
				if (gap_q != GAP_MAX) begin
					gap_n = gap_q + 10'd1;
				end
				if (mode_q == MODE_ONCE) begin
					if (elapsed_n > timeout_q) begin
						error_n   = ERR_TIMEOUT;
						mode_n    = MODE_ERROR;
						elapsed_n = '0;
					end else if (!item_s1.gimbal_busy) begin
						if (!item_s1.target_valid) begin
							error_n = ERR_NO_TARGET;
						end else if (on_target) begin
							error_n   = ERR_NONE;
							mode_n    = MODE_LOCKED;
							elapsed_n = '0;
						end else begin
							do_move = 1'b1;
						end
					end
				end else if (mode_q == MODE_TRACK) begin
					if (!item_s1.gimbal_busy && gap_n >= track_interval_q) begin
						gap_n = '0;
						if (!item_s1.target_valid) begin
							error_n = ERR_NO_TARGET;
						end else if (on_target) begin
							error_n = ERR_NONE;
						end else begin
							do_move = 1'b1;
						end
					end
				end
			end
			CMD_START_ONCE, CMD_START_TRACK: begin
				elapsed_n = '0;
				if (!item_s1.calibrated) begin
					error_n = ERR_CAL;
					mode_n  = MODE_ERROR;
				end else begin
					error_n        = ERR_NONE;
					res_n.start_ok = 1'b1;
					if (item_s1.cmd == CMD_START_ONCE) begin
						timeout_n = (item_s1.once_tmo == 16'd0) ?
							default_timeout_q : item_s1.once_tmo;
						gap_n     = '0;
						mode_n    = MODE_ONCE;
					end else begin
						gap_n  = GAP_MAX;
						mode_n = MODE_TRACK;
					end
				end
			end
			CMD_STOP: begin
				res_n.stop_request = 1'b1;
				mode_n             = MODE_IDLE;
				elapsed_n          = '0;
			end
			default: ;
		endcase

		// move issue, a refused move ends in error
		if (do_move) begin
			res_n.move_request = 1'b1;
			res_n.move_x       = item_s1.err_x;
			res_n.move_y       = item_s1.err_y;
			if (!item_s1.move_accepted) begin
				error_n   = item_s1.calibrated ? ERR_GIMBAL : ERR_CAL;
				mode_n    = MODE_ERROR;
				elapsed_n = '0;
			end
		end

		res_n.mode            = mode_n;
		res_n.last_error      = error_n;
		res_n.mode_elapsed_ms = elapsed_n;
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			mode_q    <= MODE_IDLE;
			error_q   <= ERR_NONE;
			elapsed_q <= '0;
			gap_q     <= '0;
			timeout_q <= DEFAULT_TIMEOUT_RST;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2  <= 1'b1;
				mode_q    <= mode_n;
				error_q   <= error_n;
				elapsed_q <= elapsed_n;
				gap_q     <= gap_n;
				timeout_q <= timeout_n;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= cmd_item;
		end
		if (adv_s2) begin
			item_s2 <= res_n;
		end
	end

endmodule

`default_nettype wire

[design/als_checker.sv]
// ----------------------------------------------------------------------------
// als_checker
// Port-level checks of the aim lock sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "aim_lock_sequencer_assert.svh"

module als_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                res_valid,
	input wire                res_stall,
	input als_pkg::als_out_t  res_item
);
	import als_pkg::*;

	// a stalled result transfer keeps its payload
	`ALS_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_item))

	// an accepted start leaves an active mode with no error
	`ALS_ASSERT_MSG(a_start_mode, res_valid && res_item.start_ok |-> (res_item.mode == MODE_ONCE || res_item.mode == MODE_TRACK) && res_item.last_error == ERR_NONE, "start accepted without active mode")

	// stop always lands in idle with a fresh elapsed count
	`ALS_ASSERT_MSG(a_stop_idle, res_valid && res_item.stop_request |-> res_item.mode == MODE_IDLE && res_item.mode_elapsed_ms == 16'd0, "stop did not reach idle")

	// error mode always carries a cause, locked mode never does
	`ALS_ASSERT(a_err_cause, res_valid && res_item.mode == MODE_ERROR |-> res_item.last_error != ERR_NONE)
	`ALS_ASSERT(a_lock_clean, res_valid && res_item.mode == MODE_LOCKED |-> res_item.last_error == ERR_NONE)

endmodule

bind aim_lock_sequencer als_checker u_als_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

`default_nettype wire
